@@ hw/rtl/handheld_bus_address_decoder_unit_assert.svh @@
// Assertion macros for the decoder's port-level checker file.
`ifndef HANDHELD_BUS_ADDRESS_DECODER_UNIT_ASSERT_SVH
`define HANDHELD_BUS_ADDRESS_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define HBAD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define HBAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

@@ hw/rtl/hbad_pkg.sv @@
// Types, memory map constants and boot image for the bus address decoder.
package hbad_pkg;

  localparam int WORK_RAM_DEPTH_DEF = 8192;
  // I/O bytes, high RAM and the interrupt-enable byte share one page store.
  localparam int HP_DEPTH = 256;
  localparam int HP_AW    = 8;

  localparam logic [15:0] VRAM_BASE      = 16'h8000;
  localparam logic [15:0] CRAM_BASE      = 16'hA000;
  localparam logic [15:0] WRAM_BASE      = 16'hC000;
  localparam logic [15:0] OAM_BASE       = 16'hFE00;
  localparam logic [15:0] KEYS_ADDR      = 16'hFF00;
  localparam logic [15:0] HRAM_BASE      = 16'hFF80;
  localparam logic [15:0] IE_ADDR        = 16'hFFFF;
  localparam logic [15:0] DIV_ADDR       = 16'hFF04;
  localparam logic [15:0] DMA_ADDR       = 16'hFF46;
  localparam logic [15:0] BOOT_EXIT_ADDR = 16'h0100;
  localparam logic [7:0]  OAM_LIMIT      = 8'hA0;

  typedef enum logic [2:0] {
    ROUTE_LOCAL   = 3'd0,
    ROUTE_CROM    = 3'd1,
    ROUTE_VRAM    = 3'd2,
    ROUTE_CRAM    = 3'd3,
    ROUTE_OAM     = 3'd4,
    ROUTE_KEYS    = 3'd5,
    ROUTE_DMA     = 3'd6,
    ROUTE_IGNORED = 3'd7
  } route_e;

  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_BOOT  = 2'd1,
    RD_WRAM  = 2'd2,
    RD_HPAGE = 2'd3
  } rd_sel_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } clr_state_e;

  typedef struct packed {
    route_e      route;
    logic [14:0] offset;
    logic        is_write;
    logic [7:0]  out_data;
    rd_sel_e     rd_sel;
    logic        wram_we;
    logic        hp_we;
    logic [7:0]  hp_idx;
    logic [7:0]  hp_wdata;
    logic        ovl_clr;
  } dec_t;

  localparam logic [7:0] BOOT_IMAGE [256] = '{
    8'h31, 8'hFE, 8'hFF, 8'hAF, 8'h21, 8'hFF, 8'h9F, 8'h32,
    8'hCB, 8'h7C, 8'h20, 8'hFB, 8'h21, 8'h26, 8'hFF, 8'h0E,
    8'h11, 8'h3E, 8'h80, 8'h32, 8'hE2, 8'h0C, 8'h3E, 8'hF3,
    8'hE2, 8'h32, 8'h3E, 8'h77, 8'h77, 8'h3E, 8'hFC, 8'hE0,
    8'h47, 8'h11, 8'h04, 8'h01, 8'h21, 8'h10, 8'h80, 8'h1A,
    8'hCD, 8'h95, 8'h00, 8'hCD, 8'h96, 8'h00, 8'h13, 8'h7B,
    8'hFE, 8'h34, 8'h20, 8'hF3, 8'h11, 8'hD8, 8'h00, 8'h06,
    8'h08, 8'h1A, 8'h13, 8'h22, 8'h23, 8'h05, 8'h20, 8'hF9,
    8'h3E, 8'h19, 8'hEA, 8'h10, 8'h99, 8'h21, 8'h2F, 8'h99,
    8'h0E, 8'h0C, 8'h3D, 8'h28, 8'h08, 8'h32, 8'h0D, 8'h20,
    8'hF9, 8'h2E, 8'h0F, 8'h18, 8'hF3, 8'h67, 8'h3E, 8'h64,
    8'h57, 8'hE0, 8'h42, 8'h3E, 8'h91, 8'hE0, 8'h40, 8'h04,
    8'h1E, 8'h02, 8'h0E, 8'h0C, 8'hF0, 8'h44, 8'hFE, 8'h90,
    8'h20, 8'hFA, 8'h0D, 8'h20, 8'hF7, 8'h1D, 8'h20, 8'hF2,
    8'h0E, 8'h13, 8'h24, 8'h7C, 8'h1E, 8'h83, 8'hFE, 8'h62,
    8'h28, 8'h06, 8'h1E, 8'hC1, 8'hFE, 8'h64, 8'h20, 8'h06,
    8'h7B, 8'hE2, 8'h0C, 8'h3E, 8'h87, 8'hF2, 8'hF0, 8'h42,
    8'h90, 8'hE0, 8'h42, 8'h15, 8'h20, 8'hD2, 8'h05, 8'h20,
    8'h4F, 8'h16, 8'h20, 8'h18, 8'hCB, 8'h4F, 8'h06, 8'h04,
    8'hC5, 8'hCB, 8'h11, 8'h17, 8'hC1, 8'hCB, 8'h11, 8'h17,
    8'h05, 8'h20, 8'hF5, 8'h22, 8'h23, 8'h22, 8'h23, 8'hC9,
    8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
    8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
    8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
    8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
    8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
    8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E,
    8'h3C, 8'h42, 8'hB9, 8'hA5, 8'hB9, 8'hA5, 8'h42, 8'h3C,
    8'h21, 8'h04, 8'h01, 8'h11, 8'hA8, 8'h00, 8'h1A, 8'h13,
    8'hBE, 8'h20, 8'hFE, 8'h23, 8'h7D, 8'hFE, 8'h34, 8'h20,
    8'hF5, 8'h06, 8'h19, 8'h78, 8'h86, 8'h23, 8'h05, 8'h20,
    8'hFB, 8'h86, 8'h20, 8'hFE, 8'h3E, 8'h01, 8'hE0, 8'h50
  };

endpackage

@@ hw/rtl/handheld_bus_address_decoder_unit.sv @@
// Top level of the handheld bus address decoder with its local stores.
// A result passes through the issue stage and the output register before it is offered.
// Throughput: one request per cycle while results are taken, since each request makes at
// most one access to the work RAM or the high page store, in the cycle it is accepted.
// Reset: the overlay turns on and a clearing pass over the work RAM entries zeroes
// both stores, with s_axis_tready held low until it is done.
module handheld_bus_address_decoder_unit #(
  parameter int WORK_RAM_DEPTH = hbad_pkg::WORK_RAM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // bus_address[15:0], write_data[23:16]
  input  logic [0:0]  s_axis_tuser,  // opcode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // local_offset[14:0], out_data[22:15],
                                     // read_data[30:23], zero[31]
  output logic [3:0]  m_axis_tuser   // route[2:0], is_write[3]
);
  import hbad_pkg::*;

  localparam int WaW = $clog2(WORK_RAM_DEPTH);

  // The request is decoded combinationally in the cycle it is accepted.
  dec_t dec;
  logic overlay_q;

  hbad_decode #(
    .WORK_RAM_DEPTH(WORK_RAM_DEPTH)
  ) u_decode (
    .opcode_i    (s_axis_tuser[0]),
    .addr_i      (s_axis_tdata[15:0]),
    .wdata_i     (s_axis_tdata[23:16]),
    .overlay_on_i(overlay_q),
    .dec_o       (dec)
  );

  // Reset clearing: one work RAM entry per cycle, and one high page entry below 256.
  clr_state_e     state_q, state_d;
  logic [WaW-1:0] clr_q, clr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == WaW'(WORK_RAM_DEPTH - 1)) begin
          state_d = ST_RUN;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  logic clearing;
  assign clearing = (state_q == ST_CLEAR);

  // Handshake. The issue stage holds the decoded request while its store read
  // completes; the output register lets the next request issue while a result waits.
  logic s1_valid_q;
  logic out_valid_q;
  logic advance;
  logic accept;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !clearing && (!s1_valid_q || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The overlay flag changes at accept, so the very next request sees the new map.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overlay_q <= 1'b1;
    end else if (accept && dec.ovl_clr) begin
      overlay_q <= 1'b0;
    end
  end

  // Work RAM: one port, written on a write request or by the clearing pass,
  // read only when a read request issues so that its output holds during a stall.
  logic [7:0]     wram_mem [WORK_RAM_DEPTH];
  logic [7:0]     wram_rd_q;
  logic           wram_we;
  logic [WaW-1:0] wram_addr;
  logic [7:0]     wram_wdata;

  always_comb begin
    if (clearing) begin
      wram_we    = 1'b1;
      wram_addr  = clr_q;
      wram_wdata = 8'h00;
    end else begin
      wram_we    = accept && dec.wram_we;
      wram_addr  = dec.offset[WaW-1:0];
      wram_wdata = s_axis_tdata[23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wram_we) begin
      wram_mem[wram_addr] <= wram_wdata;
    end
    if (accept && dec.rd_sel == RD_WRAM) begin
      wram_rd_q <= wram_mem[wram_addr];
    end
  end

  // High page store, indexed by the low address byte: I/O bytes, high RAM and
  // the interrupt-enable byte at the top entry.
  logic [7:0]       hp_mem [HP_DEPTH];
  logic [7:0]       hp_rd_q;
  logic             hp_we;
  logic [HP_AW-1:0] hp_addr;
  logic [7:0]       hp_wdata;

  always_comb begin
    if (clearing) begin
      hp_we    = (clr_q < WaW'(HP_DEPTH));
      hp_addr  = clr_q[HP_AW-1:0];
      hp_wdata = 8'h00;
    end else begin
      hp_we    = accept && dec.hp_we;
      hp_addr  = dec.hp_idx;
      hp_wdata = dec.hp_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hp_we) begin
      hp_mem[hp_addr] <= hp_wdata;
    end
    if (accept && dec.rd_sel == RD_HPAGE) begin
      hp_rd_q <= hp_mem[hp_addr];
    end
  end

  // Issue stage registers.
  route_e      s1_route_q;
  logic [14:0] s1_offset_q;
  logic        s1_is_write_q;
  logic [7:0]  s1_out_data_q;
  rd_sel_e     s1_rd_sel_q;
  logic [7:0]  s1_boot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_route_q    <= dec.route;
      s1_offset_q   <= dec.offset;
      s1_is_write_q <= dec.is_write;
      s1_out_data_q <= dec.out_data;
      s1_rd_sel_q   <= dec.rd_sel;
      s1_boot_q     <= BOOT_IMAGE[dec.offset[7:0]];
    end
  end

  // Pick the byte that the issued read returns; writes and routed accesses get zero.
  logic [7:0] s1_read_data;

  always_comb begin
    unique case (s1_rd_sel_q)
      RD_NONE:  s1_read_data = 8'h00;
      RD_BOOT:  s1_read_data = s1_boot_q;
      RD_WRAM:  s1_read_data = wram_rd_q;
      RD_HPAGE: s1_read_data = hp_rd_q;
      default:  s1_read_data = 8'h00;
    endcase
  end

  // Output register.
  logic [31:0] out_tdata_q;
  logic [3:0]  out_tuser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_tdata_q <= {1'b0, s1_read_data, s1_out_data_q, s1_offset_q};
      out_tuser_q <= {s1_is_write_q, s1_route_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_tuser_q;

endmodule

@@ hw/rtl/hbad_decode.sv @@
// Address decoder: maps one bus request onto a route, an offset and store controls.
module hbad_decode #(
  parameter int WORK_RAM_DEPTH = hbad_pkg::WORK_RAM_DEPTH_DEF
) (
  input  logic           opcode_i,
  input  logic [15:0]    addr_i,
  input  logic [7:0]     wdata_i,
  input  logic           overlay_on_i,
  output hbad_pkg::dec_t dec_o
);
  import hbad_pkg::*;

  localparam int WaW = $clog2(WORK_RAM_DEPTH);

  logic [13:0]    wram_ext;
  logic [13:0]    wram_wrap;
  logic [WaW-1:0] wram_idx;

  // The work RAM and its echo both land on the low 13 address bits; a smaller
  // RAM wraps by one subtract, which suffices only while the value stays below twice the depth.
  always_comb begin
    wram_ext = {1'b0, addr_i[12:0]};
    if (wram_ext >= 14'(WORK_RAM_DEPTH)) begin
      wram_wrap = wram_ext - 14'(WORK_RAM_DEPTH);
    end else begin
      wram_wrap = wram_ext;
    end
    wram_idx = wram_wrap[WaW-1:0];
  end

  always_comb begin
    dec_o          = '0;
    dec_o.route    = ROUTE_IGNORED;
    dec_o.rd_sel   = RD_NONE;
    dec_o.is_write = opcode_i;
    dec_o.out_data = opcode_i ? wdata_i : 8'h00;
    dec_o.hp_idx   = addr_i[7:0];
    dec_o.hp_wdata = wdata_i;

    if (addr_i < VRAM_BASE) begin
      if (overlay_on_i && addr_i <= BOOT_EXIT_ADDR) begin
        if (addr_i == BOOT_EXIT_ADDR) begin
          // Reading the exit address unmaps the boot ROM and still goes to the cartridge.
          dec_o.route   = ROUTE_CROM;
          dec_o.offset  = addr_i[14:0];
          dec_o.ovl_clr = !opcode_i;
        end else if (!opcode_i) begin
          dec_o.route  = ROUTE_LOCAL;
          dec_o.offset = addr_i[14:0];
          dec_o.rd_sel = RD_BOOT;
        end
      end else begin
        dec_o.route  = ROUTE_CROM;
        dec_o.offset = addr_i[14:0];
      end
    end else if (addr_i < CRAM_BASE) begin
      dec_o.route  = ROUTE_VRAM;
      dec_o.offset = {2'b00, addr_i[12:0]};
    end else if (addr_i < WRAM_BASE) begin
      dec_o.route  = ROUTE_CRAM;
      dec_o.offset = {2'b00, addr_i[12:0]};
    end else if (addr_i < OAM_BASE) begin
      dec_o.route   = ROUTE_LOCAL;
      dec_o.offset  = 15'(wram_idx);
      dec_o.wram_we = opcode_i;
      dec_o.rd_sel  = opcode_i ? RD_NONE : RD_WRAM;
    end else if (addr_i < KEYS_ADDR) begin
      if (addr_i[7:0] < OAM_LIMIT) begin
        dec_o.route  = ROUTE_OAM;
        dec_o.offset = {7'b0, addr_i[7:0]};
      end
    end else if (addr_i == KEYS_ADDR) begin
      dec_o.route = ROUTE_KEYS;
    end else if (addr_i < HRAM_BASE) begin
      if (opcode_i && addr_i == DMA_ADDR) begin
        dec_o.route  = ROUTE_DMA;
        dec_o.offset = {7'b0, wdata_i};
      end else begin
        dec_o.route    = ROUTE_LOCAL;
        dec_o.offset   = {8'b0, addr_i[6:0]};
        dec_o.hp_we    = opcode_i;
        dec_o.hp_wdata = (addr_i == DIV_ADDR) ? 8'h00 : wdata_i;
        dec_o.rd_sel   = opcode_i ? RD_NONE : RD_HPAGE;
      end
    end else if (addr_i == IE_ADDR) begin
      dec_o.route  = ROUTE_LOCAL;
      dec_o.hp_we  = opcode_i;
      dec_o.rd_sel = opcode_i ? RD_NONE : RD_HPAGE;
    end else begin
      dec_o.route  = ROUTE_LOCAL;
      dec_o.offset = {8'b0, addr_i[6:0]};
      dec_o.hp_we  = opcode_i;
      dec_o.rd_sel = opcode_i ? RD_NONE : RD_HPAGE;
    end
  end

endmodule

@@ hw/rtl/hbad_checker.sv @@
// Port-level checker for the bus address decoder, bound to its top level.
`include "handheld_bus_address_decoder_unit_assert.svh"

module hbad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);
  import hbad_pkg::*;

  logic        out_stall;
  logic        out_write;
  route_e      out_route;
  logic        out_no_rdata;
  logic [14:0] out_offset;
  logic [7:0]  out_wdata;
  logic [7:0]  out_rdata;

  assign out_stall    = m_axis_tvalid && !m_axis_tready;
  assign out_write    = m_axis_tuser[3];
  assign out_route    = route_e'(m_axis_tuser[2:0]);
  assign out_no_rdata = out_write || (out_route != ROUTE_LOCAL);
  assign out_offset   = m_axis_tdata[14:0];
  assign out_wdata    = m_axis_tdata[22:15];
  assign out_rdata    = m_axis_tdata[30:23];

  // A stalled result keeps its contents.
  `HBAD_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))

  // A read passes no write byte on.
  `HBAD_ASSERT_IMPL(a_read_no_wdata, m_axis_tvalid && !out_write, out_wdata == 8'h00)

  // A write returns no read byte, and neither does any routed-out access.
  `HBAD_ASSERT_IMPL(a_rdata_zero, m_axis_tvalid && out_no_rdata, out_rdata == 8'h00)

  // Ignored accesses carry no offset.
  `HBAD_ASSERT_IMPL(a_ignored_off, m_axis_tvalid && out_route == ROUTE_IGNORED, out_offset == '0)

endmodule

bind handheld_bus_address_decoder_unit hbad_checker u_hbad_checker (.*);

@@ verif/handheld_bus_address_decoder_unit_checker.sv @@
// Checker that predicts every decoder request and compares the results in order.
module handheld_bus_address_decoder_unit_checker #(
  parameter int WORK_RAM_DEPTH = hbad_pkg::WORK_RAM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // bus_address[15:0], write_data[23:16]
  input  logic [0:0]  s_axis_tuser,  // opcode[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // local_offset[14:0], out_data[22:15],
                                     // read_data[30:23], zero[31]
  input  logic [3:0]  m_axis_tuser,  // route[2:0], is_write[3]
  output int          pending_o,
  output int          mismatches_o
);
  import hbad_pkg::*;

  localparam int IO_BYTES   = 128;
  localparam int HIGH_BYTES = 127;

  typedef struct packed {
    route_e      route;
    logic [14:0] offset;
    logic        is_write;
    logic [7:0]  out_data;
    logic [7:0]  read_data;
  } bus_result_t;

  logic [7:0]  work_ram [WORK_RAM_DEPTH];
  logic [7:0]  io_bytes [IO_BYTES];
  logic [7:0]  high_ram [HIGH_BYTES];
  logic [7:0]  irq_enable;
  logic        boot_overlay_on;
  bus_result_t expected_q [$];
  int          mismatch_count;

  // Decodes one access against the memory map and applies its side effects.
  function automatic bus_result_t decode_access(input logic wr, input logic [15:0] a,
                                                input logic [7:0] d);
    bus_result_t r;
    logic [7:0]  rd;
    int          idx;
    r.route  = ROUTE_IGNORED;
    r.offset = '0;
    rd       = '0;
    if (a < VRAM_BASE) begin
      if (boot_overlay_on && a <= BOOT_EXIT_ADDR) begin
        if (a == BOOT_EXIT_ADDR) begin
          // Reading the exit address drops the overlay; the access itself is cartridge.
          r.route  = ROUTE_CROM;
          r.offset = a[14:0];
          if (!wr) boot_overlay_on = 1'b0;
        end else if (!wr) begin
          r.route  = ROUTE_LOCAL;
          r.offset = a[14:0];
          rd       = BOOT_IMAGE[a[7:0]];
        end
      end else begin
        r.route  = ROUTE_CROM;
        r.offset = a[14:0];
      end
    end else if (a < CRAM_BASE) begin
      r.route  = ROUTE_VRAM;
      r.offset = 15'(a - VRAM_BASE);
    end else if (a < WRAM_BASE) begin
      r.route  = ROUTE_CRAM;
      r.offset = 15'(a - CRAM_BASE);
    end else if (a < OAM_BASE) begin
      // The echo region folds back onto work RAM.
      idx      = int'((a - WRAM_BASE) & 16'h1FFF) % WORK_RAM_DEPTH;
      r.route  = ROUTE_LOCAL;
      r.offset = 15'(idx);
      if (wr) work_ram[idx] = d;
      else rd = work_ram[idx];
    end else if (a < KEYS_ADDR) begin
      if (16'(a - OAM_BASE) < 16'(OAM_LIMIT)) begin
        r.route  = ROUTE_OAM;
        r.offset = 15'(a - OAM_BASE);
      end
    end else if (a == KEYS_ADDR) begin
      r.route = ROUTE_KEYS;
    end else if (a < HRAM_BASE) begin
      idx = int'(a - KEYS_ADDR);
      if (wr && a == DMA_ADDR) begin
        r.route  = ROUTE_DMA;
        r.offset = 15'(d);
      end else begin
        r.route  = ROUTE_LOCAL;
        r.offset = 15'(idx);
        if (wr) io_bytes[idx] = (a == DIV_ADDR) ? 8'h00 : d;
        else rd = io_bytes[idx];
      end
    end else if (a == IE_ADDR) begin
      r.route = ROUTE_LOCAL;
      if (wr) irq_enable = d;
      else rd = irq_enable;
    end else begin
      idx      = int'(a - HRAM_BASE);
      r.route  = ROUTE_LOCAL;
      r.offset = 15'(idx);
      if (wr) high_ram[idx] = d;
      else rd = high_ram[idx];
    end
    r.is_write  = wr;
    r.out_data  = wr ? d : 8'h00;
    r.read_data = wr ? 8'h00 : rd;
    return r;
  endfunction

  always @(posedge clk_i) begin
    bus_result_t want;
    bus_result_t got;
    if (!rst_ni) begin
      foreach (work_ram[i]) work_ram[i] = '0;
      foreach (io_bytes[i]) io_bytes[i] = '0;
      foreach (high_ram[i]) high_ram[i] = '0;
      irq_enable      = '0;
      boot_overlay_on = 1'b1;
      mismatch_count  = 0;
      expected_q.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      // Results are registered before they leave, so compare before predicting.
      if (m_axis_tvalid && m_axis_tready) begin
        got.route     = route_e'(m_axis_tuser[2:0]);
        got.is_write  = m_axis_tuser[3];
        got.offset    = m_axis_tdata[14:0];
        got.out_data  = m_axis_tdata[22:15];
        got.read_data = m_axis_tdata[30:23];
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: route %0d offset %h wr %b out %h rd %h",
                     got.route, got.offset, got.is_write, got.out_data, got.read_data);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: route %0d/%0d offset %h/%h wr %b/%b out %h/%h rd %h/%h",
                       want.route, got.route, want.offset, got.offset,
                       want.is_write, got.is_write, want.out_data, got.out_data,
                       want.read_data, got.read_data);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(decode_access(s_axis_tuser[0], s_axis_tdata[15:0],
                                           s_axis_tdata[23:16]));
      pending_o    <= expected_q.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

@@ verif/handheld_bus_address_decoder_unit_test.sv @@
// Testbench top for the bus address decoder: request stimulus, result sink and verdict.
module handheld_bus_address_decoder_unit_test;
  import hbad_pkg::*;

  localparam int WORK_RAM_DEPTH = WORK_RAM_DEPTH_DEF;
  // Covers the clearing pass after reset and the long result hold-off with room to spare.
  localparam int QUIET_LIMIT    = 40000;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } bus_op_e;

  // Region borders of the memory map, used to bias random addresses.
  localparam logic [15:0] BORDER_ADDRS [23] = '{
    16'h0000, 16'h00FF, 16'h0100, 16'h0101, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000,
    16'hBFFF, 16'hC000, 16'hDFFF, 16'hE000, 16'hFDFF, 16'hFE00, 16'hFE9F, 16'hFEA0,
    16'hFEFF, 16'hFF00, 16'hFF01, 16'hFF7F, 16'hFF80, 16'hFFFE, 16'hFFFF
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  int          pending;
  int          mismatches;
  int          quiet_cycles  = 0;

  always #6 clk_i = ~clk_i;

  handheld_bus_address_decoder_unit #(
    .WORK_RAM_DEPTH(WORK_RAM_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  handheld_bus_address_decoder_unit_checker #(
    .WORK_RAM_DEPTH(WORK_RAM_DEPTH)
  ) access_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  // Offers one request, idling first unless steady, and returns at the edge that takes it.
  task automatic send_request(input bus_op_e op, input logic [15:0] addr,
                              input logic [7:0] data, input bit steady);
    while (!steady && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, addr};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Waits until every predicted result has come back. The extra edge lets the
  // checker's count catch up with the last accepted request.
  task automatic drain_results();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly local stores and borders, so that reads find data written earlier.
  function automatic logic [15:0] pick_address();
    logic [15:0] hot;
    hot = 16'(16'hC000 + $urandom_range(63));
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(16'h0101));
      2:       return $urandom_range(1) ? hot : 16'(hot + 16'h2000);
      3:       return 16'($urandom_range(16'hFDFF, 16'hC000));
      4:       return 16'($urandom_range(16'hFEFF, 16'hFE00));
      5:       return 16'($urandom_range(16'hFF7F, 16'hFF00));
      6: begin
        case ($urandom_range(3))
          0:       return DIV_ADDR;
          1:       return DMA_ADDR;
          2:       return KEYS_ADDR;
          default: return IE_ADDR;
        endcase
      end
      7:       return 16'($urandom_range(16'hFFFF, 16'hFF80));
      8:       return BORDER_ADDRS[$urandom_range(22)];
      default: return 16'($urandom_range(16'hBFFF, 16'h8000));
    endcase
  endfunction

  // Random requests; while the overlay must stay on, exit reads become writes.
  task automatic random_requests(input int count, input bit keep_overlay);
    bus_op_e     op;
    logic [15:0] addr;
    for (int k = 0; k < count; k++) begin
      op   = bus_op_e'($urandom_range(1));
      addr = pick_address();
      if (keep_overlay && op == OP_READ && addr == BOOT_EXIT_ADDR) op = OP_WRITE;
      send_request(op, addr, 8'($urandom), k >= count / 4 && k < count / 2);
    end
  endtask

  // Request side: directed accesses, random traffic under the overlay, the
  // overlay exit, then random traffic over the full map.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Boot ROM ends and writes that the overlay swallows.
    send_request(OP_READ,  16'h0000, 8'h00, 1'b0);
    send_request(OP_READ,  16'h00FF, 8'hFF, 1'b0);
    send_request(OP_WRITE, 16'h0000, 8'hFF, 1'b0);
    send_request(OP_WRITE, 16'h00FF, 8'h00, 1'b0);
    // A write to the exit address goes to the cartridge and keeps the overlay.
    send_request(OP_WRITE, 16'h0100, 8'h5A, 1'b0);
    send_request(OP_READ,  16'h7FFF, 8'h00, 1'b0);
    send_request(OP_WRITE, 16'h8000, 8'hFF, 1'b0);
    send_request(OP_READ,  16'h9FFF, 8'h00, 1'b0);
    send_request(OP_WRITE, 16'hA000, 8'hA5, 1'b0);
    send_request(OP_READ,  16'hBFFF, 8'h00, 1'b0);
    // Work RAM through its base and through the echo.
    send_request(OP_WRITE, 16'hC000, 8'hFF, 1'b0);
    send_request(OP_READ,  16'hE000, 8'h00, 1'b0);
    send_request(OP_WRITE, 16'hFDFF, 8'h5A, 1'b0);
    send_request(OP_READ,  16'hDDFF, 8'h00, 1'b0);
    // Sprite RAM and its ignored tail.
    send_request(OP_READ,  16'hFE00, 8'h00, 1'b0);
    send_request(OP_WRITE, 16'hFE9F, 8'h3C, 1'b0);
    send_request(OP_READ,  16'hFEA0, 8'hFF, 1'b0);
    send_request(OP_WRITE, 16'hFEFF, 8'hFF, 1'b0);
    send_request(OP_READ,  KEYS_ADDR, 8'h00, 1'b0);
    // The divider clears on any write; the DMA write leaves its byte alone.
    send_request(OP_WRITE, DIV_ADDR, 8'h77, 1'b0);
    send_request(OP_READ,  DIV_ADDR, 8'h00, 1'b0);
    send_request(OP_WRITE, DMA_ADDR, 8'hC1, 1'b0);
    send_request(OP_READ,  DMA_ADDR, 8'h00, 1'b0);
    send_request(OP_WRITE, 16'hFF01, 8'h81, 1'b0);
    send_request(OP_READ,  16'hFF01, 8'h00, 1'b0);
    send_request(OP_WRITE, 16'hFF80, 8'h12, 1'b0);
    send_request(OP_READ,  16'hFFFE, 8'h00, 1'b0);
    send_request(OP_WRITE, IE_ADDR,  8'hAB, 1'b0);
    send_request(OP_READ,  IE_ADDR,  8'h00, 1'b0);
    s_axis_tvalid <= 1'b0;
    drain_results();

    random_requests(600, 1'b1);

    // Leave the overlay; the low area then belongs to the cartridge.
    send_request(OP_READ,  BOOT_EXIT_ADDR, 8'h00, 1'b0);
    send_request(OP_READ,  16'h0000, 8'h00, 1'b0);
    send_request(OP_READ,  16'h00FF, 8'h00, 1'b0);
    send_request(OP_READ,  BOOT_EXIT_ADDR, 8'h00, 1'b0);
    send_request(OP_WRITE, 16'h0050, 8'h99, 1'b0);

    random_requests(1220, 1'b0);
    s_axis_tvalid <= 1'b0;
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("handheld_bus_address_decoder_unit_test OK");
    end else begin
      $display("handheld_bus_address_decoder_unit_test NOT OK");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off that backs the decoder up into
  // its request port, and a stretch that takes every result at once.
  initial begin
    int taken;
    int hold_left;
    bit held;
    taken     = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!held && taken >= 700) begin
        held      = 1'b1;
        hold_left = 300;
        m_axis_tready <= 1'b0;
      end else if (taken >= 1100 && taken < 1400) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 17);
      end
    end
  end

  // Ends the run if neither side moves a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("handheld_bus_address_decoder_unit_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
